[sv/radial_vignette_pixel_assert.svh]
// Assertion macros for the radial vignette pixel block.
// Included inside the module body; expects clk and rst in scope.
`ifndef RADIAL_VIGNETTE_PIXEL_ASSERT_SVH
`define RADIAL_VIGNETTE_PIXEL_ASSERT_SVH

// Consequent checked on the same edge as the antecedent.
`define RVP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked on the edge after the antecedent.
`define RVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rvp_pkg.sv]
// Package for the radial vignette pixel block: sizes, register indexes
// and the exponential weight table. No dependencies.
`default_nettype none

package rvp_pkg;

  localparam int COORD_BITS      = 12;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int IDX_FULL_W      = 13;

  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int unsigned COORD_MASK_INT = (32'd1 << COORD_BITS) - 32'd1;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_MASK_INT[COORD_W-1:0];

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF      = 3'd4;

  typedef logic [EXP_TABLE_DEPTH-1:0][WEIGHT_W-1:0] weight_rom_t;

  // Truncating 64-bit quotient by shift and subtract, used only while
  // building the table at elaboration.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(65535 * exp(-i/32)), built from exp(-1/32) in Q0.62 by its series.
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t   rom;
    logic [63:0]   term;
    logic [63:0]   q;
    logic [63:0]   w;
    logic [127:0]  prod;
    logic [127:0]  rnd;
    int            k;
    int            i;
    term = 64'd1 << 62;
    q    = 64'd1 << 62;
    w    = 64'd1 << 62;
    for (k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        term = long_div(term, 64'(k) << 5);
        if (k[0]) q = q - term;
        else q = q + term;
      end
    end
    for (i = 0; i < EXP_TABLE_DEPTH; i++) begin
      prod   = 128'(w) * 128'd65535;
      rnd    = prod + (128'd1 << 61);
      rom[i] = rnd[62 +: WEIGHT_W];
      prod   = 128'(w) * 128'(q);
      w      = prod[62 +: 64];
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

`default_nettype wire

[sv/radial_vignette_pixel.sv]
// Radial vignette: Gaussian-shaped attenuation, one RGB pixel per clock
// while unstalled. Depends on rvp_pkg and radial_vignette_pixel_assert.svh.
`default_nettype none

// Accepts one pixel per clock and returns one result per pixel, in order,
// through the seven-stage pipeline: offset multiply, round/saturate, squares,
// radius sum, falloff multiply, weight table read, channel scaling. When the
// output is stalled the whole pipeline holds, so throughput is one pixel per
// clock while the sink keeps up. Registers are written over the cfg port and
// should only change while no pixel is in flight.
module radial_vignette_pixel (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // col[11:0], row[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
  input  wire  [rvp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [rvp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire                            cfg_we,
  input  wire  [rvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [rvp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rvp_pkg::*;

  localparam int STAGES = 7;

  // configuration
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [16:0] inv_center_x;
  logic [16:0] inv_center_y;
  logic [7:0]  falloff;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= 12'd320;
      center_y     <= 12'd240;
      inv_center_x <= 17'd205;
      inv_center_y <= 17'd273;
      falloff      <= 8'd48;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data[11:0];
        REG_CENTER_Y:     center_y     <= cfg_data[11:0];
        REG_INV_CENTER_X: inv_center_x <= cfg_data;
        REG_INV_CENTER_Y: inv_center_y <= cfg_data;
        REG_FALLOFF:      falloff      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [STAGES-1:0] vld;
  logic              adv;

  assign adv           = !vld[STAGES-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], s_axis_tvalid};
    end
  end

  // input unpack
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [23:0]        rgb_in;

  assign col    = s_axis_tdata[11:0] & COORD_MASK;
  assign row    = s_axis_tdata[23:12] & COORD_MASK;
  assign rgb_in = s_axis_tdata[47:24];

  // stage 1: offset times reciprocal, Q.16
  logic signed [12:0] diff_x;
  logic signed [12:0] diff_y;
  logic signed [30:0] px;
  logic signed [30:0] py;
  logic [23:0]        rgb1;

  assign diff_x = $signed({1'b0, col}) - $signed({1'b0, center_x});
  assign diff_y = $signed({1'b0, row}) - $signed({1'b0, center_y});

  always_ff @(posedge clk) begin
    if (adv) begin
      px   <= 31'(diff_x) * 31'($signed({1'b0, inv_center_x}));
      py   <= 31'(diff_y) * 31'($signed({1'b0, inv_center_y}));
      rgb1 <= rgb_in;
    end
  end

  // stage 2: round to Q2.14 and saturate
  logic signed [30:0] px_rnd;
  logic signed [30:0] py_rnd;
  logic signed [28:0] vx;
  logic signed [28:0] vy;
  logic signed [15:0] sat_x;
  logic signed [15:0] sat_y;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [23:0]        rgb2;

  assign px_rnd = px + 31'sd2;
  assign py_rnd = py + 31'sd2;
  assign vx     = px_rnd[30:2];
  assign vy     = py_rnd[30:2];

  always_comb begin
    if (vx > 29'sd32767) sat_x = 16'sh7fff;
    else if (vx < -29'sd32768) sat_x = 16'sh8000;
    else sat_x = vx[15:0];
    if (vy > 29'sd32767) sat_y = 16'sh7fff;
    else if (vy < -29'sd32768) sat_y = 16'sh8000;
    else sat_y = vy[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx   <= sat_x;
      dy   <= sat_y;
      rgb2 <= rgb1;
    end
  end

  // stage 3: squares, Q3.28
  logic signed [31:0] sq_x_full;
  logic signed [31:0] sq_y_full;
  logic [30:0]        sq_x;
  logic [30:0]        sq_y;
  logic [23:0]        rgb3;

  assign sq_x_full = 32'(dx) * 32'(dx);
  assign sq_y_full = 32'(dy) * 32'(dy);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x <= sq_x_full[30:0];
      sq_y <= sq_y_full[30:0];
      rgb3 <= rgb2;
    end
  end

  // stage 4: squared radius
  logic [31:0] r2;
  logic [23:0] rgb4;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2   <= 32'(sq_x) + 32'(sq_y);
      rgb4 <= rgb3;
    end
  end

  // stage 5: exponent rounded to Q3.5
  logic [39:0]           expo;
  logic [40:0]           expo_rnd;
  logic [IDX_FULL_W-1:0] idx_full;
  logic                  idx_in_range;
  logic [IDX_W-1:0]      idx;
  logic                  idx_hit;
  logic [23:0]           rgb5;

  assign expo         = 40'(r2) * 40'(falloff);
  assign expo_rnd     = 41'(expo) + (41'd1 << 26);
  assign idx_full     = expo_rnd[27 +: IDX_FULL_W];
  assign idx_in_range = idx_full < IDX_FULL_W'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (adv) begin
      idx     <= idx_full[IDX_W-1:0];
      idx_hit <= idx_in_range;
      rgb5    <= rgb4;
    end
  end

  // stage 6: weight lookup
  logic [WEIGHT_W-1:0] w;
  logic [23:0]         rgb6;

  always_ff @(posedge clk) begin
    if (adv) begin
      w    <= idx_hit ? WEIGHT_ROM[idx] : '0;
      rgb6 <= rgb5;
    end
  end

  // stage 7: channel scaling with rounding
  logic [24:0] prod_r;
  logic [24:0] prod_g;
  logic [24:0] prod_b;

  assign prod_r = 25'(rgb6[7:0] * w) + 25'd32768;
  assign prod_g = 25'(rgb6[15:8] * w) + 25'd32768;
  assign prod_b = 25'(rgb6[23:16] * w) + 25'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {prod_b[23:16], prod_g[23:16], prod_r[23:16]};
    end
  end

  `include "radial_vignette_pixel_assert.svh"

  `RVP_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld[0],
    "accepted pixel did not enter the pipeline")
  `RVP_ASSERT_NEXT(a_stall_holds, !adv, vld == $past(vld),
    "pipeline valid bits changed during a stall")
  `RVP_ASSERT_NEXT(a_past_table_zero, adv && vld[4] && !idx_hit, w == '0,
    "index past the table gave a nonzero weight")

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for radial_vignette_pixel: a table of directed pixels and then random phases.
// Random phases may write new register settings. Each result is checked against a typed
// expectation or a predictor computed in this file. Depends on rvp_pkg and the RTL.
`default_nettype none

module tb;
  import rvp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1750;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // set_fo: write falloff to fo before this pixel; typed: exp_* holds the result
  typedef struct packed {
    logic         set_fo;
    logic [7:0]   fo;
    logic [11:0]  col;
    logic [11:0]  row;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         typed;
    logic [7:0]   exp_red;
    logic [7:0]   exp_green;
    logic [7:0]   exp_blue;
  } pixel_case_t;

  localparam int N_DIRECTED = 17;
  localparam pixel_case_t DIRECTED [N_DIRECTED] = '{
    // reset settings
    '{1'b0, 8'd0,   12'd320,  12'd240,  8'd255, 8'd0,   8'd128, 1'b1, 8'd255, 8'd0,   8'd128},
    '{1'b0, 8'd0,   12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd0,    12'd0,    8'd200, 8'd100, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd0,    12'd4095, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd4095, 12'd0,    8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd321,  12'd240,  8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd640,  12'd240,  8'd255, 8'd128, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'hAAA,  12'h555,  8'hAA,  8'h55,  8'hAA,  1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'h555,  12'hAAA,  8'h55,  8'hAA,  8'h55,  1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, 8'd0,   12'd320,  12'd240,  8'd1,   8'd254, 8'd127, 1'b1, 8'd1,   8'd254, 8'd127},
    // zero falloff: full weight everywhere
    '{1'b1, 8'd0,   12'd0,    12'd0,    8'd255, 8'd17,  8'd1,   1'b1, 8'd255, 8'd17,  8'd1},
    '{1'b1, 8'd0,   12'd4095, 12'd4095, 8'd200, 8'd100, 8'd50,  1'b1, 8'd200, 8'd100, 8'd50},
    '{1'b1, 8'd0,   12'd320,  12'd240,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    // steepest falloff
    '{1'b1, 8'd255, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
    '{1'b1, 8'd255, 12'd330,  12'd240,  8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b1, 8'd255, 12'd320,  12'd250,  8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b1, 8'd255, 12'd320,  12'd240,  8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // col[11:0], row[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers, reset values
  logic [11:0] vig_cx = 12'd320;
  logic [11:0] vig_cy = 12'd240;
  logic [16:0] vig_inv_x = 17'd205;
  logic [16:0] vig_inv_y = 17'd273;
  logic [7:0]  vig_falloff = 8'd48;

  weight_t                gauss_lut [EXP_TABLE_DEPTH];
  logic [OUT_DATA_W-1:0]  expected_pix [$];
  int                     mismatches = 0;
  int                     cycles = 0;
  bit                     steady = 1'b0;

  radial_vignette_pixel u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // exp(-1/32) in Q0.62 from its series, then successive powers
  initial begin : build_lut
    logic [63:0]  term;
    logic [63:0]  ratio;
    logic [63:0]  acc;
    logic [127:0] wide;
    int           k;
    term  = 64'd1 << 62;
    ratio = term;
    acc   = term;
    for (k = 1; k < 40 && term != 64'd0; k++) begin
      term = term / (64'd32 * 64'(k));
      if (k % 2 == 1) ratio = ratio - term;
      else ratio = ratio + term;
    end
    for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
      wide         = 128'(acc) * 128'd65535 + (128'd1 << 61);
      gauss_lut[k] = wide[62 +: WEIGHT_W];
      wide         = 128'(acc) * 128'(ratio);
      acc          = wide[62 +: 64];
    end
  end

  // offset from center times reciprocal, rounded to Q2.14 and clamped
  function automatic longint norm_offset(input logic [11:0] pos, input logic [11:0] center,
                                         input logic [16:0] recip);
    longint prod;
    longint v;
    prod = (longint'(pos) - longint'(center)) * longint'(recip);
    v = (prod + 2) >>> 2;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input weight_t w);
    logic [31:0] t;
    t = 32'(c) * 32'(w) + 32'd32768;
    return t[23:16];
  endfunction

  function automatic logic [OUT_DATA_W-1:0] vignette_pixel(input logic [IN_DATA_W-1:0] beat);
    longint  dx;
    longint  dy;
    longint  expo;
    weight_t w;
    dx   = norm_offset(beat[11:0] & COORD_MASK, vig_cx, vig_inv_x);
    dy   = norm_offset(beat[23:12] & COORD_MASK, vig_cy, vig_inv_y);
    expo = ((dx * dx + dy * dy) * longint'(vig_falloff) + (longint'(1) << 26)) >>> 27;
    w    = (expo < EXP_TABLE_DEPTH) ? gauss_lut[int'(expo)] : '0;
    return {scale_chan(beat[47:40], w), scale_chan(beat[39:32], w), scale_chan(beat[31:24], w)};
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_CENTER_X:     vig_cx = value[11:0];
      REG_CENTER_Y:     vig_cy = value[11:0];
      REG_INV_CENTER_X: vig_inv_x = value[16:0];
      REG_INV_CENTER_Y: vig_inv_y = value[16:0];
      REG_FALLOFF:      vig_falloff = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [IN_DATA_W-1:0] beat, input bit typed,
                            input logic [OUT_DATA_W-1:0] typed_res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    expected_pix.push_back(typed ? typed_res : vignette_pixel(beat));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sink: random stalls, checks each result transaction
  initial begin : result_check
    int                    stall;
    logic [OUT_DATA_W-1:0] want;
    string                 field_name [3];
    field_name = '{"red_out", "green_out", "blue_out"};
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      if (expected_pix.size() == 0) begin
        note_mismatch("unexpected result, red_out", 8'd0, m_axis_tdata[7:0]);
      end else begin
        want = expected_pix.pop_front();
        for (int f = 0; f < 3; f++)
          if (m_axis_tdata[8*f +: 8] !== want[8*f +: 8])
            note_mismatch(field_name[f], want[8*f +: 8], m_axis_tdata[8*f +: 8]);
      end
    end
  end

  initial begin : stimulus
    pixel_case_t     pc;
    int              phase;
    int              burst;
    int              sent;
    int              span_x;
    int              span_y;
    int              axis;
    logic [11:0]     cval;
    logic [16:0]     inv;
    logic [7:0]      fo;
    logic [11:0]     col;
    logic [11:0]     row;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      pc = DIRECTED[i];
      if (pc.set_fo && pc.fo != vig_falloff) begin
        wait_idle();
        cfg_write(REG_FALLOFF, {9'd0, pc.fo});
        cfg_we <= 1'b0;
      end
      send_pixel({pc.blue, pc.green, pc.red, pc.row, pc.col}, pc.typed,
                 {pc.exp_blue, pc.exp_green, pc.exp_red});
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      for (axis = 0; axis < 2; axis++) begin
        case (phase)
          0: cval = 12'd1;
          1: cval = 12'd2048;
          default:
            case ($urandom_range(0, 5))
              0: cval = 12'd1;
              1: cval = 12'd2048;
              2: cval = 12'($urandom_range(1, 4095));
              default: cval = 12'($urandom_range(1, 2048));
            endcase
        endcase
        // upper data bits beyond the register width are junk now and then
        if (phase < 2 || $urandom_range(0, 1) == 1)
          cfg_write(axis == 1 ? REG_CENTER_Y : REG_CENTER_X,
                    ($urandom_range(0, 3) == 0) ? {5'($urandom), cval} : {5'd0, cval});
        cval = (axis == 1) ? vig_cy : vig_cx;
        case (phase)
          0: inv = 17'd65536;
          1: inv = 17'd32;
          default:
            case ($urandom_range(0, 5))
              0: inv = 17'($urandom_range(32, 65536));
              1: inv = 17'($urandom);
              2: inv = ($urandom_range(0, 1) == 1) ? 17'd32 : 17'd65536;
              default: inv = 17'(65536 / int'(cval));
            endcase
        endcase
        if (phase < 2 || $urandom_range(0, 1) == 1)
          cfg_write(axis == 1 ? REG_INV_CENTER_Y : REG_INV_CENTER_X, inv);
      end
      case (phase)
        0: fo = 8'd255;
        1: fo = 8'd0;
        default:
          case ($urandom_range(0, 4))
            0: fo = 8'd0;
            1: fo = 8'd255;
            2: fo = 8'd48;
            default: fo = 8'($urandom_range(0, 255));
          endcase
      endcase
      if (phase < 2 || $urandom_range(0, 1) == 1)
        cfg_write(REG_FALLOFF, {9'd0, fo});
      // unmapped index, must leave every register alone
      if (phase == 0 || $urandom_range(0, 3) == 0)
        cfg_write(CFG_IDX_W'(REG_FALLOFF + CFG_IDX_W'($urandom_range(1, 3))), 17'($urandom));
      cfg_we <= 1'b0;

      steady = ($urandom_range(0, 3) == 0);
      span_x = (3 * int'(vig_cx) > 4095) ? 4095 : 3 * int'(vig_cx);
      span_y = (3 * int'(vig_cy) > 4095) ? 4095 : 3 * int'(vig_cy);
      burst  = $urandom_range(40, 200);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      repeat (burst) begin
        // mostly inside the lit region, some anywhere in the coordinate range
        if ($urandom_range(0, 4) == 0) begin
          col = 12'($urandom);
          row = 12'($urandom);
        end else begin
          col = 12'($urandom_range(0, span_x));
          row = 12'($urandom_range(0, span_y));
        end
        if ($urandom_range(0, 9) == 0) begin
          red   = 8'd255;
          green = 8'd255;
          blue  = 8'd255;
        end else begin
          red   = 8'($urandom);
          green = 8'($urandom);
          blue  = 8'($urandom);
        end
        send_pixel({blue, green, red, row, col}, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
